// ----- rtl/core/drs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drs_pkg: disk request scheduler shared definitions
// payload types, register indexes, policy codes and engine states
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int MAX_REQUESTS_DEF = 16;
    localparam int CYL_W            = 16;
    localparam int SEEK_W           = 24;
    localparam int CFG_ADDR_W       = 1;
    localparam int CFG_DATA_W       = 16;

    localparam logic [CYL_W-1:0]  TOP_RESET = 16'd4999;
    localparam logic [SEEK_W-1:0] SEEK_MAX  = 24'hFFFFFF;

    localparam logic [CFG_ADDR_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOP    = 1'b1;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SSTF = 2'd1;
    localparam logic [1:0] POL_SCAN = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [CYL_W-1:0] cylinder;
    } t_in;

    typedef struct packed {
        logic [CYL_W-1:0]  served_cylinder;
        logic [SEEK_W-1:0] seek_total;
        logic              last;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    function automatic logic [CYL_W-1:0] abs_diff(input logic [CYL_W-1:0] a,
                                                  input logic [CYL_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/disk_request_scheduler_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// disk_request_scheduler_core: batch disk request scheduler
// fcfs, shortest seek first and scan (up to the top cylinder, then down) over a stored batch
// ----------------------------------------------------------------------------
// input channel: mode 0 loads one request, mode 1 starts a run
// at the given head position. the input is only ready while no run is in
// progress; a run ends when its last result has been loaded into the
// output register.
// output channel: one transfer per visited cylinder with the running seek
// total, last marks the end of the run.
// each result of a run is found by one pass over the request store (for fcfs
// only the next stored entry), one entry read per cycle from the single
// memory read port. a stalled receiver holds the output register and the
// search waits behind it.
// reset clears the batch, policy to fcfs and top cylinder to 4999; the
// store contents are not cleared.
// ----------------------------------------------------------------------------
module disk_request_scheduler_core #(
    parameter int MAX_REQUESTS = drs_pkg::MAX_REQUESTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire drs_pkg::t_in                  i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output drs_pkg::t_out                      o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [drs_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [drs_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REQUESTS);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    drs_pkg::t_state r_state, n_state;

    logic [1:0]                    r_policy;
    logic [drs_pkg::CYL_W-1:0]     r_top;
    logic [CW-1:0]                 r_count;
    logic [drs_pkg::CYL_W-1:0]     r_head;
    logic [drs_pkg::CYL_W-1:0]     r_pos;
    logic [drs_pkg::SEEK_W-1:0]    r_seek;
    logic [CW-1:0]                 r_served;
    logic                          r_down;
    logic [MAX_REQUESTS-1:0]       r_marks;
    logic [CW-1:0]                 r_addr;
    logic [CW-1:0]                 r_end;
    logic                          r_rd_vld;
    logic [IW-1:0]                 r_rd_idx;
    logic                          r_found;
    logic [drs_pkg::CYL_W-1:0]     r_best_val;
    logic [IW-1:0]                 r_best_idx;
    logic [drs_pkg::CYL_W-1:0]     r_best_key;
    logic                          r_out_vld;
    drs_pkg::t_out                 r_out;

    logic                          w_sstf, w_scan, w_fcfs;
    logic                          w_in_acc, w_load, w_run;
    logic                          w_issue, w_pass_done;
    logic [drs_pkg::CYL_W-1:0]     w_rdata, w_key, w_clamp;
    logic                          w_elig, w_better, w_take;
    logic                          w_emit, w_last;
    logic [drs_pkg::CYL_W-1:0]     w_val;
    logic [drs_pkg::SEEK_W:0]      w_sum;
    logic [drs_pkg::SEEK_W-1:0]    w_seek_n;
    logic [CW-1:0]                 w_served_n;

    assign w_sstf = (r_policy == drs_pkg::POL_SSTF);
    assign w_scan = (r_policy == drs_pkg::POL_SCAN);
    assign w_fcfs = !w_sstf && !w_scan;

    assign o_in_ready  = (r_state == drs_pkg::ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_load      = w_in_acc && (i_in_data.mode == drs_pkg::MODE_LOAD);
    assign w_run       = w_in_acc && (i_in_data.mode == drs_pkg::MODE_RUN);
    assign w_clamp     = (i_in_data.cylinder > r_top) ? r_top : i_in_data.cylinder;

    assign w_issue     = (r_state == drs_pkg::ST_SCAN) && (r_addr != r_end);
    assign w_pass_done = (r_state == drs_pkg::ST_SCAN) && !w_issue && !r_rd_vld;

    drs_req_mem #(
        .DEPTH (MAX_REQUESTS),
        .IW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_load && (r_count < CNT_MAX)),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (w_clamp),
        .i_re    (w_issue),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (w_rdata)
    );

    // candidate selection for the entry just read
    always_comb begin
        w_key    = drs_pkg::abs_diff(w_rdata, r_pos);
        w_elig   = 1'b1;
        w_better = !r_found;
        if (w_sstf) begin
            w_elig   = !r_marks[r_rd_idx];
            w_better = !r_found || (w_key < r_best_key);
        end else if (w_scan && !r_down) begin
            w_elig   = !r_marks[r_rd_idx] && (w_rdata > r_head);
            w_better = !r_found || (w_rdata < r_best_val);
        end else if (w_scan) begin
            w_elig   = !r_marks[r_rd_idx];
            w_better = !r_found || (w_rdata > r_best_val);
        end
        w_take = r_rd_vld && w_elig && w_better;
    end

    // value and flags of the result about to be emitted
    always_comb begin
        w_emit     = (r_state == drs_pkg::ST_EMIT) && (!r_out_vld || i_out_ready);
        w_served_n = r_served + CNT_ONE;
        if (r_found) begin
            w_val  = r_best_val;
            w_last = (w_served_n == r_count) && (!w_scan || r_down);
        end else begin
            w_val  = w_scan ? r_top : r_head;
            w_last = w_scan ? (r_served == r_count) : 1'b1;
        end
        w_sum    = {1'b0, r_seek} + {{(drs_pkg::SEEK_W + 1 - drs_pkg::CYL_W){1'b0}},
                    drs_pkg::abs_diff(w_val, r_pos)};
        w_seek_n = w_sum[drs_pkg::SEEK_W] ? drs_pkg::SEEK_MAX : w_sum[drs_pkg::SEEK_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            drs_pkg::ST_IDLE: begin
                if (w_run) begin
                    n_state = ((r_count == '0) && !w_scan) ? drs_pkg::ST_EMIT
                                                            : drs_pkg::ST_SCAN;
                end
            end
            drs_pkg::ST_SCAN: begin
                if (w_pass_done) begin
                    n_state = drs_pkg::ST_EMIT;
                end
            end
            drs_pkg::ST_EMIT: begin
                if (w_emit) begin
                    n_state = w_last ? drs_pkg::ST_IDLE : drs_pkg::ST_SCAN;
                end
            end
            default: n_state = drs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= drs_pkg::ST_IDLE;
            r_policy <= drs_pkg::POL_FCFS;
            r_top    <= drs_pkg::TOP_RESET;
            r_count  <= '0;
            r_marks  <= '0;
            r_rd_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_found  <= 1'b0;
            r_down   <= 1'b0;
            r_served <= '0;
            r_addr   <= '0;
            r_end    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_addr == drs_pkg::CFG_POLICY) begin
                    r_policy <= i_cfg_wdata[1:0];
                end else begin
                    r_top <= i_cfg_wdata;
                end
            end
            if (w_load && (r_count < CNT_MAX)) begin
                r_count <= r_count + CNT_ONE;
            end
            if (w_run) begin
                r_served <= '0;
                r_down   <= 1'b0;
                r_marks  <= '0;
                r_found  <= 1'b0;
                r_addr   <= '0;
                r_end    <= w_fcfs ? CNT_ONE : r_count;
            end
            r_rd_vld <= w_issue;
            if (w_issue) begin
                r_addr <= r_addr + CNT_ONE;
            end
            if (w_take) begin
                r_found <= 1'b1;
            end
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_emit) begin
                r_found   <= 1'b0;
                if (r_found) begin
                    r_marks[r_best_idx] <= 1'b1;
                    r_served            <= w_served_n;
                end else if (w_scan) begin
                    r_down <= 1'b1;
                end
                if (w_last) begin
                    r_count <= '0;
                end else if (w_fcfs) begin
                    r_addr <= w_served_n;
                    r_end  <= w_served_n + CNT_ONE;
                end else begin
                    r_addr <= '0;
                    r_end  <= r_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr[IW-1:0];
        if (w_run) begin
            r_head <= i_in_data.cylinder;
            r_pos  <= i_in_data.cylinder;
            r_seek <= '0;
        end
        if (w_take) begin
            r_best_val <= w_rdata;
            r_best_idx <= r_rd_idx;
            r_best_key <= w_key;
        end
        if (w_emit) begin
            r_pos                 <= w_val;
            r_seek                <= w_seek_n;
            r_out.served_cylinder <= w_val;
            r_out.seek_total      <= w_seek_n;
            r_out.last            <= w_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ----- rtl/core/drs_req_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drs_req_mem: request store
// one write port, one registered read port
// ----------------------------------------------------------------------------
module drs_req_mem #(
    parameter int DEPTH = drs_pkg::MAX_REQUESTS_DEF,
    parameter int IW    = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [IW-1:0]            i_waddr,
    input  wire logic [drs_pkg::CYL_W-1:0] i_wdata,
    input  wire logic                     i_re,
    input  wire logic [IW-1:0]            i_raddr,
    output logic      [drs_pkg::CYL_W-1:0] o_rdata
);

    logic [drs_pkg::CYL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/drs_core_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drs_core_chk: port level checks for the scheduler core
// attached to the top level by bind
// ----------------------------------------------------------------------------
module drs_core_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire drs_pkg::t_in                  i_in_data,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire drs_pkg::t_out                 o_out_data
);

    // no result straight after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a run transfer makes the block busy
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.mode == drs_pkg::MODE_RUN)
        |=> !o_in_ready)
        else $error("input ready right after run start");

    // mid-run result means run still in progress
    a_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> !o_in_ready)
        else $error("input ready before last result");

endmodule

bind disk_request_scheduler_core drs_core_chk u_drs_core_chk (.*);
`default_nettype wire
